// File: src/amt_pkg.sv
`default_nettype none

package amt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int KEY_W   = 64;
   localparam int ADDR_W  = 16;
   localparam int COUNT_W = 7;

   localparam logic [ADDR_W-1:0] NO_ENTRY = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ADDED   = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_MOVE_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key_id;
      logic [ADDR_W-1:0]  short_addr_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  short_addr_out;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_cmd_type;

endpackage

`default_nettype wire

// File: src/amt_store.sv
`default_nettype none

module amt_store (
   input  wire                   clock,
   input  amt_pkg::mem_cmd_type  mem_cmd,
   output amt_pkg::entry_type    rd_data
);
   import amt_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem[mem_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/amt_ctrl.sv
`default_nettype none

module amt_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  amt_pkg::req_type      req,
   output logic                  req_ready,
   input  wire                   out_free,
   output logic                  rsp_load,
   output amt_pkg::rsp_type      rsp_data,
   output amt_pkg::mem_cmd_type  mem_cmd,
   input  amt_pkg::entry_type    rd_data
);
   import amt_pkg::*;

   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  idx_ff;       // next slot to read
   logic [IDX_W-1:0]  chk_idx_ff;   // slot whose data sits on rd_data
   logic              chk_valid_ff;
   status_type        res_status_ff;
   logic [ADDR_W-1:0] res_addr_ff;

   logic              hit, scan_done, decide, issue, full, need_move;
   logic [CNT_W-1:0]  last_idx;

   always_comb begin
      hit       = chk_valid_ff && (rd_data.key == req_ff.key_id);
      issue     = (state_ff == S_SEARCH) && (idx_ff < count_ff);
      scan_done = !hit && (idx_ff >= count_ff);
      decide    = (state_ff == S_SEARCH) && (hit || scan_done);
      full      = (count_ff == CNT_W'(TABLE_DEPTH));
      last_idx  = count_ff - CNT_W'(1);
      need_move = (req_ff.op == OP_REMOVE) && hit && (CNT_W'(chk_idx_ff) < last_idx);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req.op == OP_NONE) ? S_RESP : S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (decide) begin
               state_in = need_move ? S_MOVE_WR : S_RESP;
            end
         end
         S_MOVE_WR: state_in = S_RESP;
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and memory port
   always_comb begin
      req_ready       = (state_ff == S_IDLE);
      rsp_load        = (state_ff == S_RESP) && out_free;
      rsp_data.status         = res_status_ff;
      rsp_data.short_addr_out = res_addr_ff;
      rsp_data.entry_count    = COUNT_W'(count_ff);

      mem_cmd         = '0;
      mem_cmd.rd_en   = issue;
      mem_cmd.rd_addr = idx_ff[IDX_W-1:0];
      if (decide && need_move) begin
         // fetch the last entry to fill the hole
         mem_cmd.rd_en   = 1'b1;
         mem_cmd.rd_addr = last_idx[IDX_W-1:0];
      end
      if (decide && (req_ff.op == OP_INSERT)) begin
         mem_cmd.wr_data.key   = req_ff.key_id;
         mem_cmd.wr_data.value = req_ff.short_addr_in;
         if (hit) begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = chk_idx_ff;
         end else if (!full) begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = count_ff[IDX_W-1:0];
         end
      end
      if (state_ff == S_MOVE_WR) begin
         mem_cmd.wr_en   = 1'b1;
         mem_cmd.wr_addr = chk_idx_ff;
         mem_cmd.wr_data = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (decide) begin
            unique case (req_ff.op)
               OP_INSERT: begin
                  if (!hit && !full) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  if (hit) begin
                     count_ff <= last_idx;
                  end
               end
               default: ;
            endcase
         end
         if ((state_ff == S_SEARCH) && !decide) begin
            chk_valid_ff <= issue;
         end else begin
            chk_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_valid) begin
         req_ff        <= req;
         idx_ff        <= '0;
         res_status_ff <= ST_MISSING;
         res_addr_ff   <= NO_ENTRY;
      end
      if ((state_ff == S_SEARCH) && !decide) begin
         chk_idx_ff <= idx_ff[IDX_W-1:0];
         if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
      if (decide) begin
         unique case (req_ff.op)
            OP_INSERT: begin
               if (hit) begin
                  res_status_ff <= ST_OK;
                  res_addr_ff   <= req_ff.short_addr_in;
               end else if (full) begin
                  res_status_ff <= ST_FULL;
               end else begin
                  res_status_ff <= ST_ADDED;
                  res_addr_ff   <= req_ff.short_addr_in;
               end
            end
            OP_LOOKUP: begin
               if (hit) begin
                  res_status_ff <= ST_OK;
                  res_addr_ff   <= rd_data.value;
               end
            end
            OP_REMOVE: begin
               if (hit) begin
                  res_status_ff <= ST_OK;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: src/address_map_table.sv
// address_map_table: 64-entry table mapping a 64-bit device id to a 16-bit
// short address.
// req_ channel: one transfer carries op (insert/lookup/remove), key_id and,
// for an insert, short_addr_in. rsp_ channel: exactly one transfer per
// request with status, short_addr_out and entry_count after the operation.
// Entries live in a single-port-read, single-port-write memory with a
// registered read. A request scans slots 0..count-1 one per cycle, stopping
// at the first match. Each slot read is registered and compared with the
// key; on a match or after the last valid entry the result is registered
// and offered from S_RESP. The unused op code goes straight to S_RESP. A
// remove that pulls the last entry into the freed slot adds a write state,
// S_MOVE_WR. req_ready returns the cycle after the result is loaded.
// One request is worked on at a time; req_ready is high only when idle.
// The result sits in an output register, so a new request is taken while
// the previous result waits on rsp_ready; a stalled receiver only holds up
// the following result, never the table contents.
// Reset (synchronous) empties the table by clearing the entry count; the
// memory itself is not cleared, slots above the count are never read.
`default_nettype none

module address_map_table (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  amt_pkg::req_type  req,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output amt_pkg::rsp_type  rsp
);
   import amt_pkg::*;

   mem_cmd_type mem_cmd;
   entry_type   rd_data;
   logic        out_free;
   logic        rsp_load;
   rsp_type     rsp_data;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // output slot is free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   amt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_ready (req_ready),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_data  (rsp_data),
      .mem_cmd   (mem_cmd),
      .rd_data   (rd_data)
   );

   amt_store u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // miss and full results never carry an address
   a_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == ST_MISSING || rsp.status == ST_FULL)
      |-> rsp.short_addr_out == NO_ENTRY)
      else $error("miss/full result with a short address");

   // the table never reports more entries than slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.entry_count <= COUNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a newly added entry leaves the table non-empty
   a_added_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == ST_ADDED |-> rsp.entry_count != '0)
      else $error("added entry with empty table");

   // one request in flight: no new transfer right after one is taken
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

endmodule

`default_nettype wire
